FILE: hdl/mcg_pkg.sv
package mcg_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_SIZE_LOG2_DEFAULT = 10;
   localparam int CHANNEL_BITS_DEFAULT  = 8;

   // Fixed field widths of the configuration register and the level tag.
   localparam int SIZE_W  = 4;
   localparam int LEVEL_W = 4;

   // Reset value of the size register, before saturation to the maximum.
   localparam int SIZE_RESET = 10;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Fill status of the queue, seen by both of its users.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

FILE: hdl/mcg_queue.sv
module mcg_queue #(
   parameter int DATA_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [DATA_W-1:0]         push_data,
   input  logic                      pop,
   output logic [DATA_W-1:0]         pop_data,
   output mcg_pkg::queue_status_type status
);
   import mcg_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_data     = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/mcg_front.sv
module mcg_front #(
   parameter int MAX_SIZE_LOG2 = mcg_pkg::MAX_SIZE_LOG2_DEFAULT,
   parameter int CHANNEL_BITS  = mcg_pkg::CHANNEL_BITS_DEFAULT,
   localparam int ENTRY_W      = 3 * CHANNEL_BITS + 2 * MAX_SIZE_LOG2 + mcg_pkg::LEVEL_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CHANNEL_BITS-1:0]    req_red,
   input  logic [CHANNEL_BITS-1:0]    req_green,
   input  logic [CHANNEL_BITS-1:0]    req_blue,
   input  logic                       csr_write_en,
   input  logic [mcg_pkg::SIZE_W-1:0] csr_write_data,
   input  mcg_pkg::queue_status_type  queue_status,
   output logic                       push,
   output logic [ENTRY_W-1:0]         push_data,
   output logic [mcg_pkg::SIZE_W-1:0] size_log2
);
   import mcg_pkg::*;

   localparam int MW = MAX_SIZE_LOG2;
   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIZE_LOG2);
   localparam logic [SIZE_W-1:0] SIZE_INIT =
      SIZE_W'((MAX_SIZE_LOG2 < SIZE_RESET) ? MAX_SIZE_LOG2 : SIZE_RESET);

   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [MW-1:0]      col_ff, col_in;
   logic [MW-1:0]      row_ff, row_in;
   logic [MW:0]        edge_last;
   logic               col_wrap, row_wrap;
   logic [LEVEL_W-1:0] emit_count;
   logic               run;

   assign req_ready = !queue_status.full;
   assign push      = req_valid && req_ready;
   assign size_log2 = size_ff;

   // Number of levels this texel completes: the run of positions, from the
   // lowest bit up, where both column and row are odd, capped at the size.
   always_comb begin
      run        = 1'b1;
      emit_count = '0;
      for (int l = 0; l < MW; l++) begin
         if (run && col_ff[l] && row_ff[l] && (SIZE_W'(l) < size_ff)) begin
            emit_count = emit_count + 1'b1;
         end else begin
            run = 1'b0;
         end
      end
   end

   assign push_data = {emit_count, row_ff, col_ff, req_blue, req_green, req_red};

   // Raster position of the next base texel.
   assign edge_last = ((MW + 1)'(1) << size_ff) - 1'b1;
   assign col_wrap  = ({1'b0, col_ff} == edge_last);
   assign row_wrap  = ({1'b0, row_ff} == edge_last);

   always_comb begin
      size_in = size_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr_write_en) begin
         // A size write saturates and restarts the texture.
         size_in = (csr_write_data > SIZE_MAX) ? SIZE_MAX : csr_write_data;
         col_in  = '0;
         row_in  = '0;
      end else if (push) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_INIT;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         size_ff <= size_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

FILE: hdl/mcg_back.sv
module mcg_back #(
   parameter int MAX_SIZE_LOG2 = mcg_pkg::MAX_SIZE_LOG2_DEFAULT,
   parameter int CHANNEL_BITS  = mcg_pkg::CHANNEL_BITS_DEFAULT,
   localparam int ENTRY_W      = 3 * CHANNEL_BITS + 2 * MAX_SIZE_LOG2 + mcg_pkg::LEVEL_W,
   localparam int COORD_W      = (MAX_SIZE_LOG2 > 1) ? MAX_SIZE_LOG2 - 1 : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mcg_pkg::queue_status_type   queue_status,
   input  logic [ENTRY_W-1:0]          pop_data,
   output logic                        pop,
   input  logic [mcg_pkg::SIZE_W-1:0]  size_log2,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mcg_pkg::LEVEL_W-1:0] rsp_level,
   output logic [COORD_W-1:0]          rsp_col,
   output logic [COORD_W-1:0]          rsp_row,
   output logic [CHANNEL_BITS-1:0]     rsp_red_avg,
   output logic [CHANNEL_BITS-1:0]     rsp_green_avg,
   output logic [CHANNEL_BITS-1:0]     rsp_blue_avg,
   output logic                        rsp_last
);
   import mcg_pkg::*;

   localparam int CB          = CHANNEL_BITS;
   localparam int MW          = MAX_SIZE_LOG2;
   localparam int PAIR_W      = CB + 1;
   localparam int STORE_DEPTH = (1 << MW) - 1;
   localparam int HOLD_IW     = (MW > 1) ? $clog2(MW) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_READ
   } state_type;

   state_type          state_ff;
   logic [CB-1:0]      px_ff [3];
   logic [MW-1:0]      col_ff;
   logic [MW-1:0]      row_ff;
   logic [LEVEL_W-1:0] emit_ff;
   logic [LEVEL_W-1:0] lvl_ff;
   logic [3*CB-1:0]    hold_ff [MW];
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [COORD_W-1:0] rsp_col_ff, rsp_row_ff;
   logic [CB-1:0]      rsp_avg_ff [3];
   logic               rsp_last_ff;

   // Pair-sum store: one entry per output column of every level.
   logic [3*PAIR_W-1:0] pair_mem [STORE_DEPTH];
   logic [3*PAIR_W-1:0] pair_rd_ff;
   logic [3*PAIR_W-1:0] pair_wdata;
   logic                pair_we;
   logic [MW:0]         lvl_offset;
   logic [MW-1:0]       pair_addr;

   logic [LEVEL_W-1:0]  lvl_m1;
   logic [HOLD_IW-1:0]  hold_idx;
   logic [3*CB-1:0]     hold_rd;
   logic [3*CB-1:0]     px_cat;
   logic [CB-1:0]       avg [3];
   logic [CB+1:0]       quad_sum [3];
   logic                level_live;
   logic                out_free;
   logic                load_rsp;

   assign lvl_m1   = lvl_ff - 1'b1;
   assign hold_idx = lvl_m1[HOLD_IW-1:0];
   assign hold_rd  = hold_ff[hold_idx];
   assign px_cat   = {px_ff[2], px_ff[1], px_ff[0]};

   assign level_live = (lvl_ff <= size_log2);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_rsp   = (state_ff == ST_READ) && out_free;
   assign pop        = (state_ff == ST_IDLE) && !queue_status.empty;

   // Entries of level L start at 2^MAX - 2^(MAX-L+1).
   assign lvl_offset = ((MW + 1)'(1) << MW) - ((MW + 1)'(1) << (MW + 1 - int'(lvl_ff)));
   assign pair_addr  = MW'(lvl_offset + (MW + 1)'(col_ff >> 1));

   // An even source row stores the horizontal pair sum of an odd column.
   assign pair_we = (state_ff == ST_LEVEL) && level_live && col_ff[0] && !row_ff[0];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pair_wdata[k*PAIR_W +: PAIR_W] = PAIR_W'(hold_rd[k*CB +: CB]) + PAIR_W'(px_ff[k]);
         quad_sum[k] = (CB + 2)'(pair_rd_ff[k*PAIR_W +: PAIR_W])
                     + (CB + 2)'(hold_rd[k*CB +: CB])
                     + (CB + 2)'(px_ff[k]);
         avg[k] = quad_sum[k][CB+1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (pair_we) begin
         pair_mem[pair_addr] <= pair_wdata;
      end
      pair_rd_ff <= pair_mem[pair_addr];
   end

   // Level sequencer: one level of the current texel per step, a store
   // read and an average for every level that the texel completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The output register loads a new result or empties on its transfer.
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!queue_status.empty) begin
                  for (int k = 0; k < 3; k++) begin
                     px_ff[k] <= pop_data[k*CB +: CB];
                  end
                  col_ff   <= pop_data[3*CB +: MW];
                  row_ff   <= pop_data[3*CB+MW +: MW];
                  emit_ff  <= pop_data[3*CB+2*MW +: LEVEL_W];
                  lvl_ff   <= LEVEL_W'(1);
                  state_ff <= ST_LEVEL;
               end
            end
            ST_LEVEL: begin
               if (!level_live) begin
                  state_ff <= ST_IDLE;
               end else if (!col_ff[0]) begin
                  // Even column: keep the texel as the left half of a pair.
                  hold_ff[hold_idx] <= px_cat;
                  state_ff          <= ST_IDLE;
               end else if (!row_ff[0]) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (out_free) begin
                  rsp_level_ff <= lvl_ff;
                  rsp_col_ff   <= COORD_W'(col_ff >> 1);
                  rsp_row_ff   <= COORD_W'(row_ff >> 1);
                  rsp_last_ff  <= (lvl_ff == emit_ff);
                  for (int k = 0; k < 3; k++) begin
                     rsp_avg_ff[k] <= avg[k];
                     px_ff[k]      <= avg[k];
                  end
                  col_ff   <= col_ff >> 1;
                  row_ff   <= row_ff >> 1;
                  lvl_ff   <= lvl_ff + 1'b1;
                  state_ff <= ST_LEVEL;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_col       = rsp_col_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_red_avg   = rsp_avg_ff[0];
   assign rsp_green_avg = rsp_avg_ff[1];
   assign rsp_blue_avg  = rsp_avg_ff[2];
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: hdl/mipmap_chain_generator.sv
// Path: a texel passes the queue, then the back's idle, level and read states,
// before its first result is registered. The back takes one texel at a time,
// with a read state per result for the registered pair-sum store read; a
// 4-entry queue lets the front take one texel per cycle until it fills.
// Reset: synchronous, active high; clears control state, sets size_log2 to
// 10 (saturated to MAX_SIZE_LOG2) and the position to (0,0). No clearing pass.
module mipmap_chain_generator #(
   parameter int MAX_SIZE_LOG2 = mcg_pkg::MAX_SIZE_LOG2_DEFAULT,
   parameter int CHANNEL_BITS  = mcg_pkg::CHANNEL_BITS_DEFAULT,
   localparam int COORD_W      = (MAX_SIZE_LOG2 > 1) ? MAX_SIZE_LOG2 - 1 : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [CHANNEL_BITS-1:0]     req_red,
   input  logic [CHANNEL_BITS-1:0]     req_green,
   input  logic [CHANNEL_BITS-1:0]     req_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mcg_pkg::LEVEL_W-1:0] rsp_level,
   output logic [COORD_W-1:0]          rsp_col,
   output logic [COORD_W-1:0]          rsp_row,
   output logic [CHANNEL_BITS-1:0]     rsp_red_avg,
   output logic [CHANNEL_BITS-1:0]     rsp_green_avg,
   output logic [CHANNEL_BITS-1:0]     rsp_blue_avg,
   output logic                        rsp_last,
   input  logic                        csr_write_en,
   input  logic [mcg_pkg::SIZE_W-1:0]  csr_write_data
);
   import mcg_pkg::*;

   localparam int ENTRY_W = 3 * CHANNEL_BITS + 2 * MAX_SIZE_LOG2 + LEVEL_W;

   queue_status_type   queue_status;
   logic               push, pop;
   logic [ENTRY_W-1:0] push_data, pop_data;
   logic [SIZE_W-1:0]  size_log2;

   // Front: accepts texels, tracks the raster position, counts results.
   mcg_front #(
      .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
      .CHANNEL_BITS  (CHANNEL_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .queue_status   (queue_status),
      .push           (push),
      .push_data      (push_data),
      .size_log2      (size_log2)
   );

   // Queue of classified texels between front and back.
   mcg_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   // Back: walks the levels and produces the averaged texels.
   mcg_back #(
      .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
      .CHANNEL_BITS  (CHANNEL_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .pop_data      (pop_data),
      .pop           (pop),
      .size_log2     (size_log2),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_level     (rsp_level),
      .rsp_col       (rsp_col),
      .rsp_row       (rsp_row),
      .rsp_red_avg   (rsp_red_avg),
      .rsp_green_avg (rsp_green_avg),
      .rsp_blue_avg  (rsp_blue_avg),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

   import mcg_pkg::*;

   localparam int MAX_LOG2     = MAX_SIZE_LOG2_DEFAULT;
   localparam int CHAN_W       = CHANNEL_BITS_DEFAULT;
   localparam int COORD_W      = (MAX_LOG2 > 1) ? MAX_LOG2 - 1 : 1;
   localparam int STORE_DEPTH  = (1 << MAX_LOG2) - 1;
   localparam int CHAN_MAX     = (1 << CHAN_W) - 1;
   localparam int DRAIN_CYCLES = 24;
   localparam int STALL_CYCLES = 300;
   localparam int WATCHDOG_MAX = 3000;

   // One texel of a generated mip level.
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [CHAN_W-1:0]  red_avg;
      logic [CHAN_W-1:0]  green_avg;
      logic [CHAN_W-1:0]  blue_avg;
      logic               last;
   } mip_texel_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CHAN_W-1:0]   req_red;
   logic [CHAN_W-1:0]   req_green;
   logic [CHAN_W-1:0]   req_blue;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [LEVEL_W-1:0]  rsp_level;
   logic [COORD_W-1:0]  rsp_col;
   logic [COORD_W-1:0]  rsp_row;
   logic [CHAN_W-1:0]   rsp_red_avg;
   logic [CHAN_W-1:0]   rsp_green_avg;
   logic [CHAN_W-1:0]   rsp_blue_avg;
   logic                rsp_last;
   logic                csr_write_en;
   logic [SIZE_W-1:0]   csr_write_data;

   // Mirror of the filter state, kept in step with accepted texels.
   logic [CHAN_W:0]     pair_sum_mem [0:STORE_DEPTH-1][0:2];
   logic [CHAN_W-1:0]   held_texel [0:MAX_LOG2-1][0:2];
   int unsigned         col_pos = 0;
   int unsigned         row_pos = 0;
   int unsigned         size_now = (SIZE_RESET > MAX_LOG2) ? MAX_LOG2 : SIZE_RESET;

   mip_texel_type       expected_texels [$];
   int                  error_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   bit                  stall_request = 0;
   int                  idle_cycles = 0;

   mipmap_chain_generator u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level      (rsp_level),
      .rsp_col        (rsp_col),
      .rsp_row        (rsp_row),
      .rsp_red_avg    (rsp_red_avg),
      .rsp_green_avg  (rsp_green_avg),
      .rsp_blue_avg   (rsp_blue_avg),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Runs one base texel through every level and queues the texels it completes.
   task automatic predict_mips(input logic [CHAN_W-1:0] red, green, blue);
      logic [CHAN_W-1:0] px [0:2];
      int unsigned       c;
      int unsigned       r;
      int unsigned       lvl;
      int unsigned       idx;
      int unsigned       sum;
      int                n;
      mip_texel_type     t;
      px[0] = red;
      px[1] = green;
      px[2] = blue;
      c = col_pos;
      r = row_pos;
      n = 0;
      for (lvl = 1; lvl <= size_now; lvl++) begin
         idx = (1 << MAX_LOG2) - (1 << (MAX_LOG2 - lvl + 1)) + (c >> 1);
         // An even column only parks its texel for the right neighbor.
         if ((c & 1) == 0) begin
            for (int k = 0; k < 3; k++) held_texel[lvl-1][k] = px[k];
            break;
         end
         if (idx >= STORE_DEPTH) break;
         // An even row stores the horizontal pair sum for the row below.
         if ((r & 1) == 0) begin
            for (int k = 0; k < 3; k++)
               pair_sum_mem[idx][k] = {1'b0, held_texel[lvl-1][k]} + {1'b0, px[k]};
            break;
         end
         for (int k = 0; k < 3; k++) begin
            sum = pair_sum_mem[idx][k] + held_texel[lvl-1][k] + px[k];
            px[k] = CHAN_W'(sum >> 2);
         end
         c = c >> 1;
         r = r >> 1;
         t.level     = LEVEL_W'(lvl);
         t.col       = COORD_W'(c);
         t.row       = COORD_W'(r);
         t.red_avg   = px[0];
         t.green_avg = px[1];
         t.blue_avg  = px[2];
         t.last      = 1'b0;
         expected_texels.push_back(t);
         n++;
      end
      // The final texel of the step carries the last flag.
      if (n > 0) begin
         t = expected_texels.pop_back();
         t.last = 1'b1;
         expected_texels.push_back(t);
      end
      col_pos++;
      if (col_pos >= (1 << size_now)) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= (1 << size_now)) row_pos = 0;
      end
   endtask

   // Channel values lean toward the extremes to hit saturation and truncation.
   function automatic logic [CHAN_W-1:0] rand_channel();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return CHAN_W'(CHAN_MAX);
         end
         default: begin
            return CHAN_W'($urandom_range(0, CHAN_MAX));
         end
      endcase
   endfunction

   // Offers one texel and holds it until the transfer; called at a falling edge.
   task automatic send_texel(input logic [CHAN_W-1:0] red, green, blue);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      do @(posedge clock); while (!req_ready);
      predict_mips(red, green, blue);
      @(negedge clock);
   endtask

   // Stops offering texels until every queued result has come back.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_texels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes the size register; the block must be idle.
   task automatic write_size(input logic [SIZE_W-1:0] code);
      csr_write_en   <= 1'b1;
      csr_write_data <= code;
      size_now = (code > MAX_LOG2) ? MAX_LOG2 : code;
      col_pos = 0;
      row_pos = 0;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_random_texels(input int count);
      repeat (count) send_texel(rand_channel(), rand_channel(), rand_channel());
   endtask

   // The reset size is the full edge, so the first texels complete nothing.
   task automatic test_reset_size();
      send_random_texels(2);
      wait_quiet();
   endtask

   // A size code above the maximum behaves as the maximum.
   task automatic test_size_saturation();
      write_size(SIZE_W'((1 << SIZE_W) - 1));
      send_random_texels(1);
      wait_quiet();
   endtask

   // A single-texel texture yields no mip texels.
   task automatic test_size_zero();
      write_size('0);
      send_random_texels(2);
      wait_quiet();
   endtask

   // One 2x2 block: full scale, zero, and a sum that truncates.
   task automatic test_single_block();
      write_size(SIZE_W'(1));
      send_texel(8'hff, 8'h00, 8'hff);
      send_texel(8'hff, 8'h00, 8'hff);
      send_texel(8'hff, 8'h00, 8'hff);
      send_texel(8'hff, 8'h00, 8'hfe);
      wait_quiet();
   endtask

   // A 4x4 texture where the last texel completes two levels at once.
   task automatic test_two_level_cascade();
      write_size(SIZE_W'(2));
      send_random_texels(16);
      wait_quiet();
   endtask

   // Mostly whole textures of small sizes, with some cut short and some odd sizes.
   task automatic test_random_textures(input int send_pct, input int recv_pct,
                                       input int item_goal);
      int sent;
      int pick;
      int count;
      int texels;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) write_size('0);
         else if (pick == 1) write_size(SIZE_W'($urandom_range(MAX_LOG2, (1 << SIZE_W) - 1)));
         else write_size(SIZE_W'($urandom_range(1, 3)));
         texels = 1 << (2 * size_now);
         if (size_now == 0) count = $urandom_range(1, 3);
         else if (size_now == MAX_LOG2) count = $urandom_range(1, 6);
         else if ($urandom_range(0, 3) == 0) count = $urandom_range(1, texels - 1);
         else count = texels * $urandom_range(1, 2);
         send_random_texels(count);
         sent += count;
         wait_quiet();
      end
   endtask

   // The receiver holds off long enough for the block to stall its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_size(SIZE_W'(3));
      stall_request = 1'b1;
      send_random_texels(64);
      wait_quiet();
   endtask

   // Result receiver: random ready, or one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
            stall_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Each result transfer is checked against the oldest expected texel.
   always @(posedge clock) begin
      mip_texel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_texels.size() == 0) begin
            $error("unexpected result texel: level %0d col %0d row %0d",
                   rsp_level, rsp_col, rsp_row);
            error_count++;
         end else begin
            want = expected_texels.pop_front();
            compare_field("level", want.level, rsp_level);
            compare_field("col", want.col, rsp_col);
            compare_field("row", want.row, rsp_row);
            compare_field("red_avg", want.red_avg, rsp_red_avg);
            compare_field("green_avg", want.green_avg, rsp_green_avg);
            compare_field("blue_avg", want.blue_avg, rsp_blue_avg);
            compare_field("last", want.last, rsp_last);
         end
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_red        = '0;
      req_green      = '0;
      req_blue       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_size();
      test_size_saturation();
      test_size_zero();
      test_single_block();
      test_two_level_cascade();
      test_random_textures(15, 76, 65);
      test_random_textures(76, 15, 65);
      test_random_textures(0, 0, 65);
      test_backpressure();
      wait_quiet();

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: mipmap_chain_generator.f
hdl/mcg_pkg.sv
hdl/mcg_queue.sv
hdl/mcg_front.sv
hdl/mcg_back.sv
hdl/mipmap_chain_generator.sv
tb/sv/tb.sv
